### rtl/scm_pkg.sv
// Package for the sprite mask collision block: field widths, opcodes,
// microcode actions and conditions, and the microcode program itself.
// Used by the request interface, the sequencer, the datapath and the top level.
package scm_pkg;

  localparam int MASK_SIZE = 32;
  localparam int ROW_W     = 5;
  localparam int POS_W     = 12;
  localparam int SPR_W     = 4;
  localparam int OP_W      = 2;
  localparam int STEP_W    = 4;
  localparam int DIFF_W    = POS_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BOX   = 2'd1,
    OP_PIXEL = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_RD_EXT_A,
    ACT_RD_EXT_B,
    ACT_BOX,
    ACT_PRIME,
    ACT_PIX,
    ACT_EMIT,
    ACT_LOAD_WR,
    ACT_EXT_UPD
  } act_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CLR_BUSY,
    COND_NO_ACCEPT,
    COND_IS_LOAD,
    COND_CHK_BAD,
    COND_BOX_MISS,
    COND_IS_BOX,
    COND_PIX_MORE,
    COND_OUT_FULL,
    COND_LOAD_BAD
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic clr_busy;
    logic no_accept;
    logic is_load;
    logic chk_bad;
    logic box_miss;
    logic is_box;
    logic pix_more;
    logic out_full;
    logic load_bad;
  } stat_t;

  localparam logic [STEP_W-1:0] STEP_CLR      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd2;
  localparam logic [STEP_W-1:0] STEP_EXT_A    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_EXT_B    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_BOX      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_BOXONLY  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_PRIME    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PIX      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd9;
  localparam logic [STEP_W-1:0] STEP_RET      = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LOAD_CHK = 4'd11;
  localparam logic [STEP_W-1:0] STEP_LOAD_WR  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_EXT_UPD  = 4'd13;

  // Control store. A step whose condition holds jumps to its target,
  // otherwise the step counter advances by one.
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      STEP_CLR:      w = '{ACT_CLEAR,    COND_CLR_BUSY,  STEP_CLR};
      STEP_IDLE:     w = '{ACT_ACCEPT,   COND_NO_ACCEPT, STEP_IDLE};
      STEP_DISPATCH: w = '{ACT_NOP,      COND_IS_LOAD,   STEP_LOAD_CHK};
      STEP_EXT_A:    w = '{ACT_RD_EXT_A, COND_CHK_BAD,   STEP_EMIT};
      STEP_EXT_B:    w = '{ACT_RD_EXT_B, COND_NEVER,     STEP_IDLE};
      STEP_BOX:      w = '{ACT_BOX,      COND_BOX_MISS,  STEP_EMIT};
      STEP_BOXONLY:  w = '{ACT_NOP,      COND_IS_BOX,    STEP_EMIT};
      STEP_PRIME:    w = '{ACT_PRIME,    COND_NEVER,     STEP_IDLE};
      STEP_PIX:      w = '{ACT_PIX,      COND_PIX_MORE,  STEP_PIX};
      STEP_EMIT:     w = '{ACT_EMIT,     COND_OUT_FULL,  STEP_EMIT};
      STEP_RET:      w = '{ACT_NOP,      COND_ALWAYS,    STEP_IDLE};
      STEP_LOAD_CHK: w = '{ACT_NOP,      COND_LOAD_BAD,  STEP_EMIT};
      STEP_LOAD_WR:  w = '{ACT_LOAD_WR,  COND_NEVER,     STEP_IDLE};
      STEP_EXT_UPD:  w = '{ACT_EXT_UPD,  COND_ALWAYS,    STEP_EMIT};
      default:       w = '{ACT_NOP,      COND_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/scm_if.sv
// Channel interfaces of the sprite mask collision block: the request
// channel and the result channel, each with valid/ready. Depends on scm_pkg.
interface scm_item_if;
  import scm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [SPR_W-1:0]        sprite_a;
  logic signed [POS_W-1:0] pos_ax;
  logic signed [POS_W-1:0] pos_ay;
  logic [SPR_W-1:0]        sprite_b;
  logic signed [POS_W-1:0] pos_bx;
  logic signed [POS_W-1:0] pos_by;
  logic [ROW_W-1:0]        row_index;
  logic [MASK_SIZE-1:0]    row_bits;

  modport source (
    output valid, opcode, sprite_a, pos_ax, pos_ay, sprite_b, pos_bx, pos_by,
           row_index, row_bits,
    input  ready
  );
  modport sink (
    input  valid, opcode, sprite_a, pos_ax, pos_ay, sprite_b, pos_bx, pos_by,
           row_index, row_bits,
    output ready
  );
endinterface

interface scm_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### rtl/scm_ram.sv
// Generic RAM: one write port and two read ports, read data registered.
// No dependencies.
module scm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/scm_useq.sv
// Microcode sequencer: step counter, control store lookup and
// conditional jump selection. Depends on scm_pkg.
module scm_useq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scm_pkg::stat_t stat_i,
  output scm_pkg::ctrl_t ctrl_o
);
  import scm_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             word;
  logic              take;

  assign word   = ucode_rom(step_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_CLR_BUSY:  take = stat_i.clr_busy;
      COND_NO_ACCEPT: take = stat_i.no_accept;
      COND_IS_LOAD:   take = stat_i.is_load;
      COND_CHK_BAD:   take = stat_i.chk_bad;
      COND_BOX_MISS:  take = stat_i.box_miss;
      COND_IS_BOX:    take = stat_i.is_box;
      COND_PIX_MORE:  take = stat_i.pix_more;
      COND_OUT_FULL:  take = stat_i.out_full;
      COND_LOAD_BAD:  take = stat_i.load_bad;
      default:        take = 1'b1;
    endcase
    step_d = take ? word.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_CLR;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### rtl/scm_dpath.sv
// Datapath: item registers, sprite extents, mask RAM with clearing pass,
// bounding-box compare and the row-pair shift-and-AND test.
// Depends on scm_pkg, scm_if and scm_ram; driven by scm_useq.
module scm_dpath #(
  parameter int SPRITE_COUNT = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scm_pkg::ctrl_t ctrl_i,
  output scm_pkg::stat_t stat_o,
  scm_item_if.sink       item_i,
  scm_result_if.source   result_o
);
  import scm_pkg::*;

  localparam int DEPTH  = SPRITE_COUNT * MASK_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SEL_W  = $clog2(SPRITE_COUNT);
  localparam int IDX_W  = (SEL_W > SPR_W) ? SEL_W : SPR_W;

  function automatic logic [MASK_SIZE-1:0] shl_row(input logic [MASK_SIZE-1:0] row,
                                                   input logic [DIFF_W-1:0] sh);
    logic [MASK_SIZE-1:0] r;
    if (sh >= DIFF_W'(MASK_SIZE)) begin
      r = '0;
    end else begin
      r = row << sh[ROW_W-1:0];
    end
    return r;
  endfunction

  // Item registers
  logic [OP_W-1:0]         op_q;
  logic [SPR_W-1:0]        a_q, b_q;
  logic signed [POS_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic [ROW_W-1:0]        row_q;
  logic [MASK_SIZE-1:0]    bits_q;

  // Work registers
  logic                    hit_q;
  logic [ROW_W-1:0]        ha_q, wa_q, hb_q, wb_q;
  logic [DIFF_W-1:0]       dxa_q, dxb_q, rya_q, ryb_q;
  logic                    pv_q;
  logic [ROW_W-1:0]        col_q;
  logic                    nz_q;
  logic [ADDR_W-1:0]       clr_q;
  logic                    out_valid_q, out_hit_q;
  logic [ROW_W-1:0]        box_h_q [SPRITE_COUNT];
  logic [ROW_W-1:0]        box_w_q [SPRITE_COUNT];

  logic                    accept, emit_fire, out_full;
  logic                    a_ok, b_ok;
  logic [IDX_W-1:0]        a_idx, b_idx;
  logic [SEL_W-1:0]        a_sel, b_sel, ext_sel;
  logic [ROW_W-1:0]        h_rd, w_rd;

  logic signed [DIFF_W:0]  axw, ayw, bxw, byw;
  logic signed [DIFF_W:0]  haw, waw, hbw, wbw;
  logic                    box_ok;
  logic                    in_rng, found;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [MASK_SIZE-1:0]    ram_wdata, rd_a, rd_b;

  logic [MASK_SIZE-1:0]    low_bit;
  logic [ROW_W-1:0]        low_idx;
  logic [ROW_W-1:0]        base_h, base_w;

  assign accept    = (ctrl_i.act == ACT_ACCEPT) && item_i.valid;
  assign out_full  = out_valid_q && !result_o.ready;
  assign emit_fire = (ctrl_i.act == ACT_EMIT) && !out_full;

  assign item_i.ready    = (ctrl_i.act == ACT_ACCEPT);
  assign result_o.valid  = out_valid_q;
  assign result_o.hit    = out_hit_q;

  assign a_ok    = int'(a_q) < SPRITE_COUNT;
  assign b_ok    = int'(b_q) < SPRITE_COUNT;
  assign a_idx   = IDX_W'(a_q);
  assign b_idx   = IDX_W'(b_q);
  assign a_sel   = a_idx[SEL_W-1:0];
  assign b_sel   = b_idx[SEL_W-1:0];
  assign ext_sel = (ctrl_i.act == ACT_RD_EXT_B) ? b_sel : a_sel;
  assign h_rd    = box_h_q[ext_sel];
  assign w_rd    = box_w_q[ext_sel];

  // Bounding boxes with inclusive extents
  assign axw = (DIFF_W + 1)'(ax_q);
  assign ayw = (DIFF_W + 1)'(ay_q);
  assign bxw = (DIFF_W + 1)'(bx_q);
  assign byw = (DIFF_W + 1)'(by_q);
  assign haw = signed'({{(DIFF_W + 1 - ROW_W){1'b0}}, ha_q});
  assign waw = signed'({{(DIFF_W + 1 - ROW_W){1'b0}}, wa_q});
  assign hbw = signed'({{(DIFF_W + 1 - ROW_W){1'b0}}, hb_q});
  assign wbw = signed'({{(DIFF_W + 1 - ROW_W){1'b0}}, wb_q});
  assign box_ok = !(axw > bxw + wbw) && !(bxw > axw + waw) &&
                  !(ayw > byw + hbw) && !(byw > ayw + haw);

  // Row pair walk: a read is issued each cycle and tested in the cycle after.
  assign in_rng = (rya_q <= DIFF_W'(ha_q)) && (ryb_q <= DIFF_W'(hb_q));
  assign found  = pv_q && (|(shl_row(rd_a, dxa_q) & shl_row(rd_b, dxb_q)));
  assign ram_raddr_a = {a_sel, rya_q[ROW_W-1:0]};
  assign ram_raddr_b = {b_sel, ryb_q[ROW_W-1:0]};

  assign ram_we    = (ctrl_i.act == ACT_CLEAR) || (ctrl_i.act == ACT_LOAD_WR);
  assign ram_waddr = (ctrl_i.act == ACT_CLEAR) ? clr_q : {a_sel, row_q};
  assign ram_wdata = (ctrl_i.act == ACT_CLEAR) ? '0 : bits_q;

  scm_ram #(
    .WIDTH (MASK_SIZE),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (rd_b)
  );

  // Rightmost opaque column: bit MASK_SIZE-1 is column 0, so the column is
  // the complement of the lowest set bit's index.
  always_comb begin
    low_bit = bits_q & (~bits_q + MASK_SIZE'(1));
    low_idx = '0;
    for (int i = 0; i < MASK_SIZE; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | ROW_W'(i);
      end
    end
  end

  // Loading row zero starts the extents over.
  assign base_h = (row_q == '0) ? '0 : box_h_q[a_sel];
  assign base_w = (row_q == '0) ? '0 : box_w_q[a_sel];

  assign stat_o.clr_busy  = (clr_q != ADDR_W'(DEPTH - 1));
  assign stat_o.no_accept = !item_i.valid;
  assign stat_o.is_load   = (op_q == OP_LOAD);
  assign stat_o.chk_bad   = !((op_q == OP_BOX) || (op_q == OP_PIXEL)) || !a_ok || !b_ok;
  assign stat_o.box_miss  = !box_ok;
  assign stat_o.is_box    = (op_q == OP_BOX);
  assign stat_o.pix_more  = pv_q && !found;
  assign stat_o.out_full  = out_full;
  assign stat_o.load_bad  = !a_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
      hit_q       <= 1'b0;
      for (int s = 0; s < SPRITE_COUNT; s++) begin
        box_h_q[s] <= '0;
        box_w_q[s] <= '0;
      end
    end else begin
      if (ctrl_i.act == ACT_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        hit_q <= 1'b0;
      end else if (ctrl_i.act == ACT_BOX) begin
        hit_q <= box_ok;
      end else if (ctrl_i.act == ACT_PIX) begin
        hit_q <= found;
      end
      if ((ctrl_i.act == ACT_PRIME) || (ctrl_i.act == ACT_PIX)) begin
        pv_q <= in_rng;
      end
      if (ctrl_i.act == ACT_EXT_UPD) begin
        box_h_q[a_sel] <= (nz_q && (row_q > base_h)) ? row_q : base_h;
        box_w_q[a_sel] <= (nz_q && (col_q > base_w)) ? col_q : base_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= item_i.opcode;
      a_q    <= item_i.sprite_a;
      ax_q   <= item_i.pos_ax;
      ay_q   <= item_i.pos_ay;
      b_q    <= item_i.sprite_b;
      bx_q   <= item_i.pos_bx;
      by_q   <= item_i.pos_by;
      row_q  <= item_i.row_index;
      bits_q <= item_i.row_bits;
    end
    if (emit_fire) begin
      out_hit_q <= hit_q;
    end
    if (ctrl_i.act == ACT_RD_EXT_A) begin
      ha_q <= h_rd;
      wa_q <= w_rd;
    end
    if (ctrl_i.act == ACT_RD_EXT_B) begin
      hb_q <= h_rd;
      wb_q <= w_rd;
    end
    if (ctrl_i.act == ACT_BOX) begin
      // The sprite further left is shifted; the one higher up skips rows.
      if (axw > bxw) begin
        dxa_q <= '0;
        dxb_q <= DIFF_W'(axw - bxw);
      end else begin
        dxa_q <= DIFF_W'(bxw - axw);
        dxb_q <= '0;
      end
      if (ayw > byw) begin
        rya_q <= '0;
        ryb_q <= DIFF_W'(ayw - byw);
      end else begin
        rya_q <= DIFF_W'(byw - ayw);
        ryb_q <= '0;
      end
    end else if ((ctrl_i.act == ACT_PRIME) || (ctrl_i.act == ACT_PIX)) begin
      rya_q <= rya_q + DIFF_W'(1);
      ryb_q <= ryb_q + DIFF_W'(1);
    end
    if (ctrl_i.act == ACT_LOAD_WR) begin
      col_q <= ROW_W'(MASK_SIZE - 1) - low_idx;
      nz_q  <= |bits_q;
    end
  end

endmodule

### rtl/sprite_mask_collision_top.sv
// Sprite mask collision block, top level: microcode sequencer plus datapath.
// Depends on scm_pkg, scm_if, scm_ram, scm_useq and scm_dpath.
//
// Usage: requests arrive on item_i (valid/ready); each accepted item yields
// exactly one result item on result_o carrying hit. Opcode 0 stores one
// 32-bit mask row of a sprite and updates its extents (hit is 0); opcode 1
// tests bounding boxes; opcode 2 tests bounding boxes and then the masks.
// Items are handled one at a time under control of a 14-step microprogram.
// A load, an unused opcode or an out-of-range sprite is answered without a
// collision test. A pixel check compares row pairs (up to 32) after a
// bounding-box hit and stops at the first common bit; the row walk issues
// one dual-port mask read per cycle and tests it in the next. The next
// item is accepted only after the result has gone valid.
// After reset all SPRITE_COUNT*32 words of the mask memory are cleared, during
// which item_i.ready stays low; extents reset at once.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver holds the sequencer at its result step.
module sprite_mask_collision_top #(
  parameter int SPRITE_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  scm_item_if.sink     item_i,
  scm_result_if.source result_o
);
  import scm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  scm_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  scm_dpath #(
    .SPRITE_COUNT (SPRITE_COUNT)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule
